// ----- hdl/spqct_pkg.sv -----
// Shared types and constants for the sprite quad corner transform.
package spqct_pkg;

  // quarter-wave sine polynomial constants, Q14
  localparam logic [15:0] QsPi      = 16'd51472;
  localparam logic [15:0] QsTwoPiM5 = 16'd21023;
  localparam logic [15:0] QsPiM3    = 16'd2320;

  localparam logic signed [26:0] VertMax = 27'sd8388607;
  localparam logic signed [26:0] VertMin = -27'sd8388608;
  localparam logic signed [41:0] RoundHalf = 42'sd16384;

  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    CornerLb = 2'd0,
    CornerRb = 2'd1,
    CornerRt = 2'd2,
    CornerLt = 2'd3
  } corner_e;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        size_x;
    logic [15:0]        size_y;
    logic [15:0]        tex_left;
    logic [15:0]        tex_top;
    logic [15:0]        tex_right;
    logic [15:0]        tex_bottom;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } sprite_t;

  typedef struct packed {
    logic signed [40:0] bx;
    logic signed [40:0] by;
    logic signed [31:0] p_xc;
    logic signed [31:0] p_ys;
    logic signed [31:0] p_xs;
    logic signed [31:0] p_yc;
    logic [15:0]        tex_left;
    logic [15:0]        tex_top;
    logic [15:0]        tex_right;
    logic [15:0]        tex_bottom;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } prep_t;

  typedef struct packed {
    corner_e            corner;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } vertex_t;

endpackage

// ----- hdl/sprite_quad_corner_transform.sv -----
// Top level of the sprite quad corner transform: front, queue and back.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | one sprite
//  out     | output    | out_valid_o / out_stall_i | one corner vertex, four a sprite
//
// Sustained rate is set by the back sequencer, which emits one vertex per cycle
// while out_stall_i is low and loads the next sprite as the last corner leaves.
// Path: 5 front stages (4 sine polynomial stages, 1 product stage), the queue,
// the corner register, then the output register.
// Reset clears all valid state at once; no clearing pass.
// in_stall_o rises when the product stage is full and the queue is full.
module sprite_quad_corner_transform #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [15:0]        size_x_i,
  input  logic [15:0]        size_y_i,
  input  logic [15:0]        angle_i,
  input  logic [15:0]        tex_left_i,
  input  logic [15:0]        tex_top_i,
  input  logic [15:0]        tex_right_i,
  input  logic [15:0]        tex_bottom_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         corner_o,
  output logic signed [23:0] vert_x_o,
  output logic signed [23:0] vert_y_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               last_corner_o
);

  spqct_pkg::sprite_t sprite;
  spqct_pkg::prep_t   prep, fifo_data;
  spqct_pkg::vertex_t vert;
  logic               prep_valid, fifo_full, fifo_valid, fifo_pop;

  always_comb begin
    sprite.pos_x      = pos_x_i;
    sprite.pos_y      = pos_y_i;
    sprite.size_x     = size_x_i;
    sprite.size_y     = size_y_i;
    sprite.tex_left   = tex_left_i;
    sprite.tex_top    = tex_top_i;
    sprite.tex_right  = tex_right_i;
    sprite.tex_bottom = tex_bottom_i;
    sprite.red        = red_i;
    sprite.green      = green_i;
    sprite.blue       = blue_i;
  end

  spqct_front #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .sprite_i (sprite),
    .angle_i  (angle_i),
    .valid_o  (prep_valid),
    .full_i   (fifo_full),
    .prep_o   (prep)
  );

  spqct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (prep_valid),
    .data_i  (prep),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  spqct_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .prep_i  (fifo_data),
    .pop_o   (fifo_pop),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .vert_o  (vert)
  );

  assign corner_o      = vert.corner;
  assign vert_x_o      = vert.vert_x;
  assign vert_y_o      = vert.vert_y;
  assign tex_u_o       = vert.tex_u;
  assign tex_v_o       = vert.tex_v;
  assign out_red_o     = vert.red;
  assign out_green_o   = vert.green;
  assign out_blue_o    = vert.blue;
  assign last_corner_o = vert.last;

  a_last_on_corner3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_corner_o == (corner_o == spqct_pkg::CornerLt)))
    else $error("last_corner out of step with corner");

  a_corners_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_corner_o)
      |=> (out_valid_o && (corner_o == $past(corner_o) + 2'd1)))
    else $error("sprite corners not delivered in consecutive order");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (prep_valid && fifo_full))
    else $error("input stalled while the queue has room");

endmodule

// ----- hdl/spqct_qsine.sv -----
// Four-stage quarter-wave sine polynomial pipeline with sign.
module spqct_qsine (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        x_i,
  input  logic               neg_i,
  output logic signed [15:0] s_o
);

  logic [15:0] st1_x_q, st1_sq_q;
  logic        st1_n_q;
  logic [15:0] st2_x_q, st2_sq_q;
  logic [11:0] st2_t_q;
  logic        st2_n_q;
  logic [15:0] st3_x_q, st3_t_q;
  logic        st3_n_q;
  logic signed [15:0] s_q;

  logic [31:0] m1, m2, m3, m4;
  logic [15:0] mag;

  assign m1  = {16'd0, x_i} * {16'd0, x_i};
  assign m2  = {16'd0, spqct_pkg::QsPiM3} * {16'd0, st1_sq_q};
  assign m3  = {16'd0, 16'(spqct_pkg::QsTwoPiM5 - {4'd0, st2_t_q})} * {16'd0, st2_sq_q};
  assign m4  = {16'd0, 16'(spqct_pkg::QsPi - st3_t_q)} * {16'd0, st3_x_q};
  assign mag = m4[31:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st1_x_q  <= x_i;
      st1_sq_q <= 16'(m1 >> 15);
      st1_n_q  <= neg_i;
      st2_x_q  <= st1_x_q;
      st2_sq_q <= st1_sq_q;
      st2_t_q  <= 12'(m2 >> 15);
      st2_n_q  <= st1_n_q;
      st3_x_q  <= st2_x_q;
      st3_t_q  <= 16'(m3 >> 15);
      st3_n_q  <= st2_n_q;
      s_q      <= st3_n_q ? $signed(16'(16'd0 - mag)) : $signed(mag);
    end
  end

  assign s_o = s_q;

endmodule

// ----- hdl/spqct_front.sv -----
// Front end: angle to sine/cosine pipeline and per-sprite products.
module spqct_front #(
  parameter int unsigned ANGLE_BITS      = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  spqct_pkg::sprite_t sprite_i,
  input  logic [15:0]        angle_i,
  output logic               valid_o,
  input  logic               full_i,
  output spqct_pkg::prep_t   prep_o
);

  localparam int unsigned Quarter = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned XSh     = 17 - SINE_TABLE_BITS;
  localparam logic [SINE_TABLE_BITS-2:0] QuarterR = (SINE_TABLE_BITS - 1)'(Quarter);
  localparam logic [SINE_TABLE_BITS-1:0] QuarterK = SINE_TABLE_BITS'(Quarter);

  function automatic logic [16:0] sine_arg(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [SINE_TABLE_BITS-3:0] r;
    logic [SINE_TABLE_BITS-2:0] rr;
    logic [15:0]                x;
    r = idx[SINE_TABLE_BITS-3:0];
    if (idx[SINE_TABLE_BITS-2]) begin
      rr = QuarterR - {1'b0, r};
    end else begin
      rr = {1'b0, r};
    end
    x = 16'(rr) << XSh;
    return {idx[SINE_TABLE_BITS-1], x};
  endfunction

  logic [ANGLE_BITS-1:0]      a_w;
  logic [SINE_TABLE_BITS-1:0] k, kc;
  logic [16:0]                arg_s, arg_c;
  logic                       pipe_en;
  logic [3:0]                 v_q;
  spqct_pkg::sprite_t         spr_q [4];
  logic signed [15:0]         sn, cs;
  logic                       prep_v_q;
  spqct_pkg::prep_t           prep_q;
  spqct_pkg::sprite_t         sp;

  assign a_w = ANGLE_BITS'(angle_i);

  if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_trunc
    assign k = a_w[ANGLE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_widen
    assign k = {a_w, {(SINE_TABLE_BITS - ANGLE_BITS){1'b0}}};
  end

  assign kc    = k + QuarterK;
  assign arg_s = sine_arg(k);
  assign arg_c = sine_arg(kc);

  assign pipe_en = !prep_v_q || !full_i;
  assign stall_o = !pipe_en;

  spqct_qsine u_sin (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (arg_s[15:0]),
    .neg_i (arg_s[16]),
    .s_o   (sn)
  );

  spqct_qsine u_cos (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (arg_c[15:0]),
    .neg_i (arg_c[16]),
    .s_o   (cs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      prep_v_q <= 1'b0;
    end else if (pipe_en) begin
      v_q      <= {v_q[2:0], valid_i};
      prep_v_q <= v_q[3];
    end
  end

  assign sp = spr_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      spr_q[0] <= sprite_i;
      spr_q[1] <= spr_q[0];
      spr_q[2] <= spr_q[1];
      spr_q[3] <= spr_q[2];
      prep_q.bx   <= {{2{sp.pos_x[23]}}, sp.pos_x, 15'd0} + {11'd0, sp.size_x, 14'd0};
      prep_q.by   <= {{2{sp.pos_y[23]}}, sp.pos_y, 15'd0} + {11'd0, sp.size_y, 14'd0};
      prep_q.p_xc <= 32'($signed({1'b0, sp.size_x})) * 32'(cs);
      prep_q.p_ys <= 32'($signed({1'b0, sp.size_y})) * 32'(sn);
      prep_q.p_xs <= 32'($signed({1'b0, sp.size_x})) * 32'(sn);
      prep_q.p_yc <= 32'($signed({1'b0, sp.size_y})) * 32'(cs);
      prep_q.tex_left   <= sp.tex_left;
      prep_q.tex_top    <= sp.tex_top;
      prep_q.tex_right  <= sp.tex_right;
      prep_q.tex_bottom <= sp.tex_bottom;
      prep_q.red        <= sp.red;
      prep_q.green      <= sp.green;
      prep_q.blue       <= sp.blue;
    end
  end

  assign valid_o = prep_v_q;
  assign prep_o  = prep_q;

endmodule

// ----- hdl/spqct_fifo.sv -----
// Short queue of prepared sprites between front and back.
module spqct_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spqct_pkg::prep_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output spqct_pkg::prep_t data_o
);

  localparam int unsigned PtrW = (spqct_pkg::FifoDepth > 1) ? $clog2(spqct_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(spqct_pkg::FifoDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(spqct_pkg::FifoDepth);
  localparam logic [PtrW-1:0] LastP  = PtrW'(spqct_pkg::FifoDepth - 1);

  spqct_pkg::prep_t mem_q [spqct_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == DepthC;
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastP) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastP) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/spqct_back.sv -----
// Back end: corner sequencer, vertex sums, rounding and saturation.
module spqct_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  spqct_pkg::prep_t   prep_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               stall_i,
  output spqct_pkg::vertex_t vert_o
);

  function automatic logic signed [23:0] round_sat(input logic signed [41:0] acc);
    logic signed [26:0] q;
    q = acc[41:15];
    if (q > spqct_pkg::VertMax) begin
      q = spqct_pkg::VertMax;
    end else if (q < spqct_pkg::VertMin) begin
      q = spqct_pkg::VertMin;
    end
    return q[23:0];
  endfunction

  spqct_pkg::prep_t   cur_q;
  logic               cur_v_q;
  spqct_pkg::corner_e cnt_q;
  logic               out_v_q;
  spqct_pkg::vertex_t out_q;
  spqct_pkg::vertex_t vert_d;
  logic               advance, cu, cv;
  logic signed [41:0] t_xc, t_ys, t_xs, t_yc, acc_x, acc_y;

  assign advance = !out_v_q || !stall_i;
  assign pop_o   = valid_i && (!cur_v_q || (advance && cnt_q == spqct_pkg::CornerLt));

  assign cu = (cnt_q == spqct_pkg::CornerRb) || (cnt_q == spqct_pkg::CornerRt);
  assign cv = (cnt_q == spqct_pkg::CornerLb) || (cnt_q == spqct_pkg::CornerRb);

  assign t_xc  = cu ? 42'(cur_q.p_xc) : -42'(cur_q.p_xc);
  assign t_xs  = cu ? 42'(cur_q.p_xs) : -42'(cur_q.p_xs);
  assign t_ys  = cv ? 42'(cur_q.p_ys) : -42'(cur_q.p_ys);
  assign t_yc  = cv ? 42'(cur_q.p_yc) : -42'(cur_q.p_yc);
  assign acc_x = 42'(cur_q.bx) + t_xc - t_ys + spqct_pkg::RoundHalf;
  assign acc_y = 42'(cur_q.by) + t_xs + t_yc + spqct_pkg::RoundHalf;

  always_comb begin
    vert_d.corner = cnt_q;
    vert_d.vert_x = round_sat(acc_x);
    vert_d.vert_y = round_sat(acc_y);
    vert_d.tex_u  = cu ? cur_q.tex_right : cur_q.tex_left;
    vert_d.tex_v  = cv ? cur_q.tex_bottom : cur_q.tex_top;
    vert_d.red    = cur_q.red;
    vert_d.green  = cur_q.green;
    vert_d.blue   = cur_q.blue;
    vert_d.last   = cnt_q == spqct_pkg::CornerLt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      cnt_q   <= spqct_pkg::CornerLb;
      out_v_q <= 1'b0;
    end else begin
      if (advance) begin
        out_v_q <= cur_v_q;
      end
      if (pop_o) begin
        cur_v_q <= 1'b1;
        cnt_q   <= spqct_pkg::CornerLb;
      end else if (advance && cur_v_q) begin
        if (cnt_q == spqct_pkg::CornerLt) begin
          cur_v_q <= 1'b0;
        end else begin
          cnt_q <= spqct_pkg::corner_e'(cnt_q + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= prep_i;
    end
    if (advance && cur_v_q) begin
      out_q <= vert_d;
    end
  end

  assign valid_o = out_v_q;
  assign vert_o  = out_q;

endmodule

// ----- tb/tb_sprite_quad_corner_transform.sv -----
// Testbench for sprite_quad_corner_transform: directed and random sprites in, four checked corners out.
`timescale 1ns / 100ps

module tb_sprite_quad_corner_transform;

  localparam int unsigned AngBits    = 16;
  localparam int unsigned TabBits    = 10;
  localparam int unsigned RShift     = (AngBits > TabBits) ? AngBits - TabBits : 0;
  localparam int unsigned LShift     = (TabBits > AngBits) ? TabBits - AngBits : 0;
  localparam int unsigned Quarter    = 1 << (TabBits - 2);
  localparam int unsigned TabMask    = (1 << TabBits) - 1;
  localparam int unsigned RandItems  = 420;
  localparam int unsigned PhaseLen   = 60;
  localparam int unsigned PressAt    = 150;
  localparam int unsigned PressLen   = 60;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainWait  = 20;
  localparam longint      VMaxL      = 64'sd8388607;
  localparam longint      VMinL      = -64'sd8388608;

  typedef struct packed {
    spqct_pkg::sprite_t spr;
    logic [15:0]        angle;
  } sprite_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] pos_x_i = '0;
  logic signed [23:0] pos_y_i = '0;
  logic [15:0]        size_x_i = '0;
  logic [15:0]        size_y_i = '0;
  logic [15:0]        angle_i = '0;
  logic [15:0]        tex_left_i = '0;
  logic [15:0]        tex_top_i = '0;
  logic [15:0]        tex_right_i = '0;
  logic [15:0]        tex_bottom_i = '0;
  logic [7:0]         red_i = '0;
  logic [7:0]         green_i = '0;
  logic [7:0]         blue_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         corner_o;
  logic signed [23:0] vert_x_o;
  logic signed [23:0] vert_y_o;
  logic [15:0]        tex_u_o;
  logic [15:0]        tex_v_o;
  logic [7:0]         out_red_o;
  logic [7:0]         out_green_o;
  logic [7:0]         out_blue_o;
  logic               last_corner_o;

  sprite_beat_t       pending_sprites[$];
  spqct_pkg::vertex_t expected_verts[$];
  int unsigned        err_count = 0;
  int unsigned        sprites_taken = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        hold_left = 0;
  bit                 press_done = 1'b0;
  bit                 in_taken = 1'b0;
  bit                 out_taken = 1'b0;

  sprite_quad_corner_transform #(
    .ANGLE_BITS(AngBits),
    .SINE_TABLE_BITS(TabBits)
  ) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .size_x_i, .size_y_i, .angle_i,
    .tex_left_i, .tex_top_i, .tex_right_i, .tex_bottom_i,
    .red_i, .green_i, .blue_i,
    .out_valid_o, .out_stall_i, .corner_o, .vert_x_o, .vert_y_o,
    .tex_u_o, .tex_v_o, .out_red_o, .out_green_o, .out_blue_o, .last_corner_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // quarter-wave polynomial, Q15 in, Q14 out, every product truncated
  function automatic longint quarter_wave(int unsigned r);
    longint unsigned x, x2, t;
    x  = longint'(r) << (15 - (TabBits - 2));
    x2 = (x * x) >> 15;
    t  = (64'd2320 * x2) >> 15;
    t  = ((64'd21023 - t) * x2) >> 15;
    t  = 64'd51472 - t;
    return longint'((x * t) >> 16);
  endfunction

  function automatic longint table_sine(int unsigned k);
    int unsigned quad, r;
    longint      s;
    quad = (k >> (TabBits - 2)) & 3;
    r    = k & (Quarter - 1);
    s    = quad[0] ? quarter_wave(Quarter - r) : quarter_wave(r);
    return quad[1] ? -s : s;
  endfunction

  function automatic logic [23:0] round_sat(longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > VMaxL) q = VMaxL;
    if (q < VMinL) q = VMinL;
    return q[23:0];
  endfunction

  task automatic predict_corners(input sprite_beat_t b);
    longint unsigned    a;
    int unsigned        k;
    longint             sn, cs, sx, sy, bx, by, dx, dy;
    spqct_pkg::vertex_t v;
    a  = longint'(b.angle) & ((64'd1 << AngBits) - 1);
    k  = int'(((a >> RShift) << LShift)) & TabMask;
    sn = table_sine(k);
    cs = table_sine((k + Quarter) & TabMask);
    sx = longint'(b.spr.size_x);
    sy = longint'(b.spr.size_y);
    bx = longint'(b.spr.pos_x) * 32768 + sx * 16384;
    by = longint'(b.spr.pos_y) * 32768 + sy * 16384;
    for (int c = 0; c < 4; c++) begin
      dx = (c == 1 || c == 2) ? sx : -sx;
      dy = (c < 2) ? sy : -sy;
      v.corner = spqct_pkg::corner_e'(c[1:0]);
      v.vert_x = round_sat(bx + dx * cs - dy * sn);
      v.vert_y = round_sat(by + dx * sn + dy * cs);
      v.tex_u  = (c == 1 || c == 2) ? b.spr.tex_right : b.spr.tex_left;
      v.tex_v  = (c < 2) ? b.spr.tex_bottom : b.spr.tex_top;
      v.red    = b.spr.red;
      v.green  = b.spr.green;
      v.blue   = b.spr.blue;
      v.last   = (c == 3);
      expected_verts.push_back(v);
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  function automatic sprite_beat_t mk_sprite(int px, int py, int sx, int sy, int ang,
                                             int tl, int tt, int tr, int tbm,
                                             int r, int g, int bl);
    sprite_beat_t b;
    b.spr.pos_x      = px[23:0];
    b.spr.pos_y      = py[23:0];
    b.spr.size_x     = sx[15:0];
    b.spr.size_y     = sy[15:0];
    b.angle          = ang[15:0];
    b.spr.tex_left   = tl[15:0];
    b.spr.tex_top    = tt[15:0];
    b.spr.tex_right  = tr[15:0];
    b.spr.tex_bottom = tbm[15:0];
    b.spr.red        = r[7:0];
    b.spr.green      = g[7:0];
    b.spr.blue       = bl[7:0];
    return b;
  endfunction

  function automatic int rand_pos();
    int p;
    if ($urandom_range(7) == 0) begin
      p = 8388607 - int'($urandom_range(40000));
      return $urandom_range(1) ? p : -p - 1;
    end
    return int'($urandom);
  endfunction

  function automatic int rand_size();
    case ($urandom_range(7))
      0, 1: return $urandom_range(255);
      2: return $urandom_range(1) ? 65535 : 0;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic sprite_beat_t rand_sprite();
    return mk_sprite(rand_pos(), rand_pos(), rand_size(), rand_size(), $urandom,
                     $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
  endfunction

  function automatic int unsigned send_idle_pct(int unsigned n);
    case ((n / PhaseLen) % 4)
      1: return 84;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(int unsigned n);
    case ((n / PhaseLen) % 4)
      2: return 84;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  // sender: new beat only when the line is empty or the last beat was taken
  always @(negedge clk_i) begin
    sprite_beat_t b;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_sprites.size() == 0 ||
          (hold_left == 0 && $urandom_range(99) < send_idle_pct(sprites_taken))) begin
        in_valid_i <= 1'b0;
      end else begin
        b = pending_sprites.pop_front();
        pos_x_i      <= b.spr.pos_x;
        pos_y_i      <= b.spr.pos_y;
        size_x_i     <= b.spr.size_x;
        size_y_i     <= b.spr.size_y;
        angle_i      <= b.angle;
        tex_left_i   <= b.spr.tex_left;
        tex_top_i    <= b.spr.tex_top;
        tex_right_i  <= b.spr.tex_right;
        tex_bottom_i <= b.spr.tex_bottom;
        red_i        <= b.spr.red;
        green_i      <= b.spr.green;
        blue_i       <= b.spr.blue;
        in_valid_i   <= 1'b1;
      end
    end
  end

  // receiver: random stall, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!press_done && sprites_taken >= PressAt) begin
      press_done  <= 1'b1;
      hold_left   <= PressLen;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct(sprites_taken));
    end
  end

  always @(posedge clk_i) begin
    spqct_pkg::vertex_t e;
    if (rst_ni) begin
      in_taken  = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (in_taken) begin
        predict_corners(mk_sprite(pos_x_i, pos_y_i, size_x_i, size_y_i, angle_i,
                                  tex_left_i, tex_top_i, tex_right_i, tex_bottom_i,
                                  red_i, green_i, blue_i));
        sprites_taken++;
      end
      if (out_taken) begin
        if (expected_verts.size() == 0) begin
          $display("%0t: unexpected vertex beat: expected none actual corner %0d x %h y %h",
                   $time, corner_o, vert_x_o, vert_y_o);
          err_count++;
        end else begin
          e = expected_verts.pop_front();
          check_field("corner", e.corner, corner_o);
          check_field("vert_x", e.vert_x, vert_x_o);
          check_field("vert_y", e.vert_y, vert_y_o);
          check_field("tex_u", e.tex_u, tex_u_o);
          check_field("tex_v", e.tex_v, tex_v_o);
          check_field("out_red", e.red, out_red_o);
          check_field("out_green", e.green, out_green_o);
          check_field("out_blue", e.blue, out_blue_o);
          check_field("last_corner", e.last, last_corner_o);
        end
      end
      quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(negedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    // zero, saturation at both ends, quarter turns, sub-step angles
    pending_sprites.push_back(mk_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_sprites.push_back(mk_sprite(8388607, 8388607, 65535, 65535, 0,
                                        0, 0, 65535, 65535, 255, 255, 255));
    pending_sprites.push_back(mk_sprite(-8388608, -8388608, 65535, 65535, 32768,
                                        65535, 65535, 0, 0, 0, 0, 0));
    pending_sprites.push_back(mk_sprite(0, 0, 256, 512, 16384, 100, 200, 300, 400, 1, 2, 3));
    pending_sprites.push_back(mk_sprite(0, 0, 256, 512, 32768, 100, 200, 300, 400, 4, 5, 6));
    pending_sprites.push_back(mk_sprite(0, 0, 256, 512, 49152, 100, 200, 300, 400, 7, 8, 9));
    pending_sprites.push_back(mk_sprite(1000, -1000, 4096, 2048, 1, 0, 0, 65535, 65535,
                                        255, 0, 255));
    pending_sprites.push_back(mk_sprite(1000, -1000, 4096, 2048, 65535, 0, 0, 65535, 65535,
                                        0, 255, 0));
    pending_sprites.push_back(mk_sprite(1000, -1000, 4096, 2048, 63, 1, 2, 3, 4, 10, 20, 30));
    pending_sprites.push_back(mk_sprite(1000, -1000, 4096, 2048, 64, 1, 2, 3, 4, 10, 20, 30));
    pending_sprites.push_back(mk_sprite(-1000, 12345, 0, 0, 12345, 5, 6, 7, 8, 40, 50, 60));
    pending_sprites.push_back(mk_sprite(0, 0, 65535, 65535, 8192, 65535, 65535, 0, 0,
                                        128, 127, 1));
    pending_sprites.push_back(mk_sprite(8388607, -8388608, 65535, 65535, 40000,
                                        12, 34, 56, 78, 254, 253, 252));
    pending_sprites.push_back(mk_sprite(-8388608, 8388607, 65535, 0, 24576,
                                        43690, 21845, 21845, 43690, 170, 85, 170));
    pending_sprites.push_back(mk_sprite(-1, -1, 1, 1, 57344, 65535, 0, 65535, 0,
                                        85, 170, 85));
    for (int i = 0; i < RandItems; i++) pending_sprites.push_back(rand_sprite());

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_sprites.size() != 0 || in_valid_i || expected_verts.size() != 0)
      @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (expected_verts.size() != 0) begin
      $display("%0t: %0d vertex beats never arrived: expected corner %0d actual none",
               $time, expected_verts.size(), expected_verts[0].corner);
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
